/* rtl/okv_pkg.sv */
// Package for the ordered key/value table: sizes, request and result types,
// action and status codes, and the stored entry layout. No dependencies.
package okv_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET    = 2'd0,
    ACT_GET    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [WORD_W-1:0]  read_value;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/okv_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
module okv_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/okv_seq.sv */
// Request sequencer: linear search, update, append and order-keeping shift
// over the entry RAM. Depends on okv_pkg.
module okv_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  okv_pkg::req_t                req,
  output logic                         res_valid,
  input  logic                         res_ready,
  output okv_pkg::rsp_t                res,
  output logic                         mem_we,
  output logic [okv_pkg::IDX_W-1:0]    mem_waddr,
  output okv_pkg::entry_t              mem_wdata,
  output logic [okv_pkg::IDX_W-1:0]    mem_raddr,
  input  okv_pkg::entry_t              mem_rdata
);
  import okv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        fill;
  logic [IDX_W-1:0]        idx;
  action_t                 act;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   val_r;
  status_t                 status_r;
  logic [VALUE_BITS-1:0]   rd_val;

  logic                    hit;
  logic                    last;
  logic                    has_room;
  logic                    shift_more;
  logic [CNT_W-1:0]        idx_plus;

  assign idx_plus   = CNT_W'(idx) + CNT_W'(1);
  assign hit        = (mem_rdata.key == key_r);
  assign last       = (idx_plus == fill);
  assign has_room   = (fill < CNT_W'(CAPACITY));
  assign shift_more = (idx_plus < fill);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status      = status_r;
    res.read_value  = WORD_W'(rd_val);
    res.entry_count = COUNT_W'(fill);
  end

  // RAM port control
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata.key   = key_r;
    mem_wdata.value = val_r;
    mem_raddr       = idx;
    case (state)
      S_SRCH_CMP: begin
        mem_we = hit && (act == ACT_SET);
      end
      S_MISS: begin
        mem_we    = (act == ACT_SET) && has_room;
        mem_waddr = fill[IDX_W-1:0];
      end
      S_SHIFT_RD: begin
        mem_raddr = idx_plus[IDX_W-1:0];
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      idx      <= '0;
      act      <= ACT_SET;
      key_r    <= '0;
      val_r    <= '0;
      status_r <= ST_OK;
      rd_val   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            act      <= req.action;
            key_r    <= req.key[KEY_BITS-1:0];
            val_r    <= req.value[VALUE_BITS-1:0];
            idx      <= '0;
            status_r <= ST_OK;
            rd_val   <= '0;
            if (req.action == ACT_CLEAR) begin
              fill  <= '0;
              state <= S_DONE;
            end else if (fill == '0) begin
              state <= S_MISS;
            end else begin
              state <= S_SRCH_RD;
            end
          end
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (hit) begin
            case (act)
              ACT_GET: begin
                rd_val <= mem_rdata.value;
                state  <= S_DONE;
              end
              ACT_REMOVE: begin
                state <= S_SHIFT_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end else if (last) begin
            state <= S_MISS;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SRCH_RD;
          end
        end
        S_MISS: begin
          if (act == ACT_SET) begin
            if (has_room) begin
              fill <= fill + CNT_W'(1);
            end else begin
              status_r <= ST_FULL;
            end
          end else begin
            status_r <= ST_NOT_FOUND;
          end
          state <= S_DONE;
        end
        S_SHIFT_RD: begin
          if (shift_more) begin
            state <= S_SHIFT_WR;
          end else begin
            fill  <= fill - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_SHIFT_WR: begin
          idx   <= idx + IDX_W'(1);
          state <= S_SHIFT_RD;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/ordered_key_value_table_unit.sv */
// Top level of the ordered key/value table: entry RAM, request sequencer and
// result output register. Depends on okv_pkg, okv_ram and okv_seq.
//
// Usage:
//   req_valid/req_ready/req carry one request (set, get, remove, clear) per
//   transfer; rsp_valid/rsp_ready/rsp carry exactly one result per request,
//   in request order, with status, read value and the entry count after it.
//   One request is worked at a time. Keys and values sit in a single RAM
//   with one read and one write port; the search reads each entry in turn
//   (address, then compare on registered data), and a remove moves each
//   later entry down one place, reading it and then writing it back.
//   The next request is taken in the cycle after the result leaves the
//   sequencer, so no new request is taken while one is being worked.
//   Reset empties the table at once; entries beyond the count are never used.
//   When the receiver stalls, the finished result holds in the output
//   register and the sequencer can take and work the next request; it then
//   waits with its result until the output register frees up.
module ordered_key_value_table_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  okv_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output okv_pkg::rsp_t rsp
);
  import okv_pkg::*;

  logic               res_valid;
  logic               res_ready;
  rsp_t               res;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata_raw;
  entry_t             mem_rdata;

  assign mem_rdata = entry_t'(mem_rdata_raw);

  okv_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (ENTRY_W'(mem_wdata)),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  okv_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: load when empty or when the current result transfers.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule
